// ===== rtl/drr_pkg.sv =====
`timescale 1ns / 1ps
package drr_pkg;

    localparam int DRR_FLOWS     = 1024;
    localparam int DRR_PKT_SLOTS = 8192;

    localparam logic [20:0] DRR_QUANTUM_MAX = 21'(1 << 20);

    // Configuration register indexes.
    localparam logic [2:0] CFG_TOTAL_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_FLOW_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_QUANTUM      = 3'd2;
    localparam logic [2:0] CFG_START_CREDIT = 3'd3;
    localparam logic [2:0] CFG_REFILL_DELAY = 3'd4;
    localparam logic [2:0] CFG_FLOW_MASK    = 3'd5;
    localparam logic [2:0] CFG_BASIC_MODE   = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_DROP_TOTAL = 3'd1;
    localparam logic [2:0] ST_DROP_FLOW  = 3'd2;
    localparam logic [2:0] ST_DEQUEUED   = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;

    typedef struct packed {
        logic [13:0] total_limit;
        logic [13:0] flow_limit;
        logic [20:0] quantum;
        logic [23:0] start_credit;
        logic [31:0] refill_delay;
        logic [9:0]  flow_mask;
        logic        basic_mode;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_IX1,
        S_IX2,
        S_E0,
        S_E1,
        S_E2,
        S_D0,
        S_D1,
        S_D2,
        S_RES
    } t_state;

endpackage

// ===== rtl/drr_ram.sv =====
`timescale 1ns / 1ps
module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/drr_cfg.sv =====
`timescale 1ns / 1ps
module drr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [2:0]    i_index,
    input  logic [31:0]   i_data,
    output drr_pkg::t_cfg o_cfg
);
    import drr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                CFG_TOTAL_LIMIT:     n_cfg.total_limit = i_data[13:0];
                CFG_FLOW_LIMIT:      n_cfg.flow_limit = i_data[13:0];
                CFG_QUANTUM: begin
                    // Out-of-range quantum writes leave the old value.
                    if (i_data[20:0] != 21'd0 && i_data[20:0] <= DRR_QUANTUM_MAX) begin
                        n_cfg.quantum = i_data[20:0];
                    end
                end
                CFG_START_CREDIT:    n_cfg.start_credit = i_data[23:0];
                CFG_REFILL_DELAY:    n_cfg.refill_delay = i_data;
                CFG_FLOW_MASK:       n_cfg.flow_mask = i_data[9:0];
                CFG_BASIC_MODE:      n_cfg.basic_mode = i_data[0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_limit     <= 14'd8192;
            r_cfg.flow_limit      <= 14'd100;
            r_cfg.quantum         <= 21'd3028;
            r_cfg.start_credit    <= 24'd15140;
            r_cfg.refill_delay    <= 32'd40;
            r_cfg.flow_mask       <= 10'd1023;
            r_cfg.basic_mode      <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== rtl/drr_idx.sv =====
`timescale 1ns / 1ps
module drr_idx #(
    parameter int FLOWS = drr_pkg::DRR_FLOWS
) (
    input  logic                     i_clk,
    input  logic [9:0]               i_val,
    output logic [$clog2(FLOWS)-1:0] o_idx
);
    import drr_pkg::*;

    localparam int FW    = $clog2(FLOWS);
    localparam int RECIP = (1 << 20) / FLOWS;

    logic [9:0]    r_v;
    logic [9:0]    r_q;
    logic [FW-1:0] r_idx;
    logic [31:0]   prod;
    logic [31:0]   rem;

    // The reciprocal quotient never overshoots, so one correction step suffices.
    assign prod = 32'(i_val) * 32'(RECIP);
    assign rem  = 32'(r_v) - 32'(r_q) * 32'(FLOWS);

    always_ff @(posedge i_clk) begin
        r_v   <= i_val;
        r_q   <= prod[29:20];
        r_idx <= (rem >= 32'(FLOWS)) ? FW'(rem - 32'(FLOWS)) : FW'(rem);
    end

    assign o_idx = r_idx;
endmodule

// ===== rtl/drr_flow_packet_scheduler.sv =====
`timescale 1ns / 1ps
// Enqueue: IX1 and IX2 reduce the hash to a flow index, E0 checks the total limit, E1 updates the
// flow entry, and E2 follows when a recycled slot is taken; a total drop goes from E0 to the result.
// Dequeue: D0 picks a flow, D1 acts on its entry and loops to D0 on a refill or detach, D2 serves;
// D0 goes straight to the result when nothing is served. One transaction is in work at a time.
// The next is accepted once the result is registered for output. Reset is synchronous, active low;
// a clearing pass then sweeps the flow table, and no input is accepted until it ends.
module drr_flow_packet_scheduler #(
    parameter int FLOWS     = drr_pkg::DRR_FLOWS,
    parameter int PKT_SLOTS = drr_pkg::DRR_PKT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_flow_hash,
    input  logic [15:0] i_pkt_len,
    input  logic [31:0] i_pkt_tag,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_out_flow,
    output logic [15:0] o_out_len,
    output logic [31:0] o_out_tag
);
    import drr_pkg::*;

    localparam int FW = $clog2(FLOWS);
    localparam int SW = $clog2(PKT_SLOTS);
    localparam int CW = $clog2(PKT_SLOTS + 1);
    localparam int LW = (CW > 14) ? CW : 14;

    typedef struct packed {
        logic          known;
        logic          listed;
        logic [31:0]   credit;
        logic [CW-1:0] count;
        logic [31:0]   idle;
        logic [SW-1:0] first;
        logic [SW-1:0] last;
    } t_flow_ent;

    typedef struct packed {
        logic          valid;
        logic [FW-1:0] first;
        logic [FW-1:0] last;
    } t_list;

    localparam int EW = $bits(t_flow_ent);

    t_cfg cfg;

    t_state r_state, n_state;
    logic [FW-1:0] r_clr, n_clr;
    logic [15:0] r_len, n_len;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_now, n_now;
    logic [9:0] r_v, n_v;
    logic [FW-1:0] r_f, n_f;
    logic r_from_new, n_from_new;
    t_list r_new, n_new, r_old, n_old;
    logic [SW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_recyc, n_recyc, r_fresh, n_fresh, r_held, n_held;
    t_flow_ent r_ent, n_ent;
    logic [2:0] r_res_status, n_res_status;
    logic [9:0] r_res_flow, n_res_flow;
    logic [15:0] r_res_len, n_res_len;
    logic [31:0] r_res_tag, n_res_tag;
    logic r_out_valid, n_out_valid;
    logic [2:0] r_out_status, n_out_status;
    logic [9:0] r_out_flow, n_out_flow;
    logic [15:0] r_out_len, n_out_len;
    logic [31:0] r_out_tag, n_out_tag;

    logic [FW-1:0] idx;
    logic [LW-1:0] limit;

    logic flow_we;
    logic [FW-1:0] flow_waddr, flow_raddr;
    t_flow_ent flow_wdata;
    logic [EW-1:0] flow_rdata;
    logic link_we;
    logic [FW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic sd_we;
    logic [SW-1:0] sd_waddr, sd_raddr;
    logic [47:0] sd_wdata, sd_rdata;
    logic sl_we;
    logic [SW-1:0] sl_waddr, sl_wdata, sl_raddr, sl_rdata;

    drr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    drr_idx #(.FLOWS(FLOWS)) u_idx (
        .i_clk (i_clk),
        .i_val (r_v),
        .o_idx (idx)
    );

    drr_ram #(.WIDTH(EW), .DEPTH(FLOWS)) u_flow_ram (
        .i_clk (i_clk), .i_we (flow_we), .i_waddr (flow_waddr), .i_wdata (flow_wdata),
        .i_raddr (flow_raddr), .o_rdata (flow_rdata)
    );

    drr_ram #(.WIDTH(FW), .DEPTH(FLOWS)) u_link_ram (
        .i_clk (i_clk), .i_we (link_we), .i_waddr (link_waddr), .i_wdata (link_wdata),
        .i_raddr (link_raddr), .o_rdata (link_rdata)
    );

    drr_ram #(.WIDTH(48), .DEPTH(PKT_SLOTS)) u_slot_ram (
        .i_clk (i_clk), .i_we (sd_we), .i_waddr (sd_waddr), .i_wdata (sd_wdata),
        .i_raddr (sd_raddr), .o_rdata (sd_rdata)
    );

    drr_ram #(.WIDTH(SW), .DEPTH(PKT_SLOTS)) u_slot_link_ram (
        .i_clk (i_clk), .i_we (sl_we), .i_waddr (sl_waddr), .i_wdata (sl_wdata),
        .i_raddr (sl_raddr), .o_rdata (sl_rdata)
    );

    assign limit = (LW'(cfg.total_limit) < LW'(PKT_SLOTS)) ? LW'(cfg.total_limit)
                                                          : LW'(PKT_SLOTS);

    always_comb begin
        t_flow_ent e;
        t_flow_ent ne;
        t_list hl;
        t_list tl;
        t_list p;
        logic [SW-1:0] s;
        logic [31:0] dt;
        logic [FW-1:0] fsel;

        n_state = r_state;
        n_clr = r_clr;
        n_len = r_len;
        n_tag = r_tag;
        n_now = r_now;
        n_v = r_v;
        n_f = r_f;
        n_from_new = r_from_new;
        n_new = r_new;
        n_old = r_old;
        n_free_head = r_free_head;
        n_recyc = r_recyc;
        n_fresh = r_fresh;
        n_held = r_held;
        n_ent = r_ent;
        n_res_status = r_res_status;
        n_res_flow = r_res_flow;
        n_res_len = r_res_len;
        n_res_tag = r_res_tag;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_status = r_out_status;
        n_out_flow = r_out_flow;
        n_out_len = r_out_len;
        n_out_tag = r_out_tag;

        flow_we = 1'b0;
        flow_waddr = r_f;
        flow_raddr = r_f;
        link_we = 1'b0;
        link_waddr = r_f;
        link_wdata = r_f;
        link_raddr = r_f;
        sd_we = 1'b0;
        sd_waddr = r_ent.first;
        sd_wdata = {r_len, r_tag};
        sd_raddr = r_ent.first;
        sl_we = 1'b0;
        sl_waddr = r_ent.first;
        sl_wdata = r_free_head;
        sl_raddr = r_ent.first;

        e = t_flow_ent'(flow_rdata);
        ne = e;
        flow_wdata = ne;
        hl = r_new;
        tl = r_old;
        p = r_from_new ? r_new : r_old;
        s = r_free_head;
        dt = 32'd0;
        fsel = r_new.valid ? r_new.first : r_old.first;

        case (r_state)
            S_CLEAR: begin
                flow_we = 1'b1;
                flow_waddr = r_clr;
                flow_wdata = '0;
                n_clr = r_clr + FW'(1);
                if (r_clr == FW'(FLOWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_len = i_pkt_len;
                    n_tag = i_pkt_tag;
                    n_now = i_now;
                    n_v = i_flow_hash[9:0] & cfg.flow_mask;
                    n_state = i_command ? S_D0 : S_IX1;
                end
            end
            S_IX1: n_state = S_IX2;
            S_IX2: n_state = S_E0;
            S_E0: begin
                n_f = idx;
                if (LW'(r_held) >= limit) begin
                    n_res_status = ST_DROP_TOTAL;
                    n_res_flow = 10'(idx);
                    n_res_len = 16'd0;
                    n_res_tag = 32'd0;
                    n_state = S_RES;
                end else begin
                    flow_raddr = idx;
                    n_state = S_E1;
                end
            end
            S_E1: begin
                if (!e.known) begin
                    ne.known = 1'b1;
                    ne.listed = 1'b0;
                    ne.credit = 32'(cfg.start_credit);
                    ne.count = '0;
                    ne.idle = r_now;
                end
                n_res_flow = 10'(r_f);
                n_res_len = 16'd0;
                n_res_tag = 32'd0;
                n_state = S_RES;
                if (LW'(ne.count) >= LW'(cfg.flow_limit)) begin
                    // A first-seen flow is still created on a flow-limit drop.
                    n_res_status = ST_DROP_FLOW;
                    flow_we = ~e.known;
                    flow_wdata = ne;
                end else begin
                    n_res_status = ST_ACCEPTED;
                    if (!ne.listed) begin
                        if (r_new.valid) begin
                            link_we = 1'b1;
                            link_waddr = r_new.last;
                        end else begin
                            n_new.first = r_f;
                        end
                        n_new.valid = 1'b1;
                        n_new.last = r_f;
                        ne.listed = 1'b1;
                        dt = ne.idle + cfg.refill_delay - r_now;
                        if (dt[31] && ne.credit < 32'(cfg.quantum)) begin
                            ne.credit = 32'(cfg.quantum);
                        end
                    end
                    s = (r_recyc != '0) ? r_free_head : r_fresh[SW-1:0];
                    sd_we = 1'b1;
                    sd_waddr = s;
                    if (ne.count == '0) begin
                        ne.first = s;
                    end else begin
                        sl_we = 1'b1;
                        sl_waddr = ne.last;
                        sl_wdata = s;
                    end
                    ne.last = s;
                    ne.count = ne.count + CW'(1);
                    flow_we = 1'b1;
                    flow_wdata = ne;
                    n_held = r_held + CW'(1);
                    if (r_recyc != '0) begin
                        sl_raddr = r_free_head;
                        n_recyc = r_recyc - CW'(1);
                        n_state = S_E2;
                    end else begin
                        n_fresh = r_fresh + CW'(1);
                    end
                end
            end
            S_E2: begin
                n_free_head = sl_rdata;
                n_state = S_RES;
            end
            S_D0: begin
                if (r_held == '0 || !(r_new.valid || (!cfg.basic_mode && r_old.valid))) begin
                    n_res_status = ST_EMPTY;
                    n_res_flow = 10'd0;
                    n_res_len = 16'd0;
                    n_res_tag = 32'd0;
                    n_state = S_RES;
                end else begin
                    n_f = fsel;
                    n_from_new = r_new.valid;
                    flow_raddr = fsel;
                    link_raddr = fsel;
                    n_state = S_D1;
                end
            end
            S_D1: begin
                if (p.first == p.last) begin
                    p.valid = 1'b0;
                end else begin
                    p.first = link_rdata;
                end
                if (r_from_new) begin
                    hl = p;
                end else begin
                    tl = p;
                end
                n_state = S_D0;
                if (e.credit == 32'd0 || e.credit[31]) begin
                    ne.credit = e.credit + 32'(cfg.quantum);
                    flow_we = 1'b1;
                    flow_wdata = ne;
                    if (cfg.basic_mode) begin
                        if (hl.valid) begin
                            link_we = 1'b1;
                            link_waddr = hl.last;
                        end else begin
                            hl.first = r_f;
                        end
                        hl.valid = 1'b1;
                        hl.last = r_f;
                    end else begin
                        if (tl.valid) begin
                            link_we = 1'b1;
                            link_waddr = tl.last;
                        end else begin
                            tl.first = r_f;
                        end
                        tl.valid = 1'b1;
                        tl.last = r_f;
                    end
                end else if (e.count == '0) begin
                    if (!cfg.basic_mode && r_from_new && r_old.valid) begin
                        link_we = 1'b1;
                        link_waddr = tl.last;
                        tl.last = r_f;
                    end else begin
                        ne.listed = 1'b0;
                        ne.idle = r_now;
                        flow_we = 1'b1;
                        flow_wdata = ne;
                    end
                end else begin
                    hl = r_new;
                    tl = r_old;
                    n_ent = e;
                    sd_raddr = e.first;
                    sl_raddr = e.first;
                    n_state = S_D2;
                end
                n_new = hl;
                n_old = tl;
            end
            S_D2: begin
                ne = r_ent;
                ne.first = sl_rdata;
                ne.count = r_ent.count - CW'(1);
                ne.credit = r_ent.credit - 32'(sd_rdata[47:32]);
                sl_we = 1'b1;
                n_free_head = r_ent.first;
                n_recyc = r_recyc + CW'(1);
                n_held = r_held - CW'(1);
                if (cfg.basic_mode && ne.count == '0) begin
                    // Basic mode detaches a flow as soon as its queue empties.
                    if (p.first == p.last) begin
                        p.valid = 1'b0;
                    end else begin
                        p.first = link_rdata;
                    end
                    if (r_from_new) begin
                        n_new = p;
                    end else begin
                        n_old = p;
                    end
                    ne.listed = 1'b0;
                    ne.idle = r_now;
                end
                flow_we = 1'b1;
                flow_wdata = ne;
                n_res_status = ST_DEQUEUED;
                n_res_flow = 10'(r_f);
                n_res_len = sd_rdata[47:32];
                n_res_tag = sd_rdata[31:0];
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_status = r_res_status;
                    n_out_flow = r_res_flow;
                    n_out_len = r_res_len;
                    n_out_tag = r_res_tag;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_new <= '0;
            r_old <= '0;
            r_free_head <= '0;
            r_recyc <= '0;
            r_fresh <= '0;
            r_held <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_new <= n_new;
            r_old <= n_old;
            r_free_head <= n_free_head;
            r_recyc <= n_recyc;
            r_fresh <= n_fresh;
            r_held <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_tag <= n_tag;
        r_now <= n_now;
        r_v <= n_v;
        r_f <= n_f;
        r_from_new <= n_from_new;
        r_ent <= n_ent;
        r_res_status <= n_res_status;
        r_res_flow <= n_res_flow;
        r_res_len <= n_res_len;
        r_res_tag <= n_res_tag;
        r_out_status <= n_out_status;
        r_out_flow <= n_out_flow;
        r_out_len <= n_out_len;
        r_out_tag <= n_out_tag;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_flow  = r_out_flow;
    assign o_out_len   = r_out_len;
    assign o_out_tag   = r_out_tag;

    // Slots in use are exactly those handed out fresh and not yet recycled.
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held == r_fresh - r_recyc)
        else $error("packet count and slot allocator disagree");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(PKT_SLOTS))
        else $error("more packets held than slots");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_IX1 || r_state == S_D0))
        else $error("accepted transaction did not start its work");
endmodule

// ===== tb/drr_flow_packet_scheduler_tb.sv =====
`timescale 1ns / 1ps
module drr_flow_packet_scheduler_tb;
    import drr_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam bit CMD_ENQ = 1'b0;
    localparam bit CMD_DEQ = 1'b1;

    typedef struct {
        bit          cmd;
        logic [31:0] hash;
        logic [15:0] len;
        logic [31:0] tag;
        logic [31:0] now;
    } t_pkt_req;

    typedef struct {
        logic [2:0]  status;
        logic [9:0]  flow;
        logic [15:0] len;
        logic [31:0] tag;
    } t_sched_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = 1'b0;
    logic [31:0] i_flow_hash = '0;
    logic [15:0] i_pkt_len = '0;
    logic [31:0] i_pkt_tag = '0;
    logic [31:0] i_now = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [9:0]  o_out_flow;
    logic [15:0] o_out_len;
    logic [31:0] o_out_tag;

    drr_flow_packet_scheduler uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Scheduler state mirrored by the testbench.
    logic [13:0] cfg_total = 14'd8192;
    logic [13:0] cfg_flow_lim = 14'd100;
    logic [20:0] cfg_quantum = 21'd3028;
    logic [23:0] cfg_init_q = 24'd15140;
    logic [31:0] cfg_refill = 32'd40;
    logic [9:0]  cfg_mask = 10'h3FF;
    logic        cfg_basic = 1'b0;

    bit          seen[DRR_FLOWS];
    bit          listed[DRR_FLOWS];
    logic [31:0] credit[DRR_FLOWS];
    int unsigned backlog[DRR_FLOWS];
    logic [31:0] idle_since[DRR_FLOWS];
    int          next_flow[DRR_FLOWS];
    int          head_slot[DRR_FLOWS];
    int          tail_slot[DRR_FLOWS];
    logic [15:0] slot_len[DRR_PKT_SLOTS];
    logic [31:0] slot_tag[DRR_PKT_SLOTS];
    int          slot_next[DRR_PKT_SLOTS];
    int          free_head = 0;
    int unsigned held = 0;
    bit          new_v = 0, old_v = 0;
    int          new_first, new_last, old_first, old_last;

    t_pkt_req    pending[$];
    t_sched_res  expected[$];
    int          errors = 0;
    int          n_status[5];
    bit          took = 0;
    int          hold_cycles = 0;
    logic [31:0] tick;

    initial begin
        for (int i = 0; i < DRR_PKT_SLOTS; i++)
            slot_next[i] = (i + 1 < DRR_PKT_SLOTS) ? i + 1 : 0;
    end

    function automatic void ring_push(bit to_old, int f);
        if (to_old) begin
            if (old_v) next_flow[old_last] = f;
            else old_first = f;
            old_v = 1;
            old_last = f;
        end else begin
            if (new_v) next_flow[new_last] = f;
            else new_first = f;
            new_v = 1;
            new_last = f;
        end
    endfunction

    function automatic void ring_pop(bit from_old);
        if (from_old) begin
            if (old_first == old_last) old_v = 0;
            else old_first = next_flow[old_first];
        end else begin
            if (new_first == new_last) new_v = 0;
            else new_first = next_flow[new_first];
        end
    endfunction

    function automatic t_sched_res enqueue_pkt(t_pkt_req r);
        t_sched_res  res;
        int          f;
        int unsigned lim;
        int          s;
        logic [31:0] due;
        f = int'(r.hash[9:0] & cfg_mask);
        lim = (cfg_total < DRR_PKT_SLOTS) ? cfg_total : DRR_PKT_SLOTS;
        res = '{ST_ACCEPTED, 10'(f), 16'd0, 32'd0};
        if (held >= lim) begin
            res.status = ST_DROP_TOTAL;
            return res;
        end
        if (!seen[f]) begin
            seen[f] = 1;
            listed[f] = 0;
            credit[f] = {8'd0, cfg_init_q};
            backlog[f] = 0;
            idle_since[f] = r.now;
        end
        if (backlog[f] >= cfg_flow_lim) begin
            res.status = ST_DROP_FLOW;
            return res;
        end
        if (!listed[f]) begin
            ring_push(0, f);
            listed[f] = 1;
            due = idle_since[f] + cfg_refill;
            // Refill only after the refill delay has passed; the sign bit of the difference handles tick wrap.
            if (((due - r.now) & 32'h8000_0000) != 0 && credit[f] < {11'd0, cfg_quantum})
                credit[f] = {11'd0, cfg_quantum};
        end
        s = free_head;
        free_head = slot_next[s];
        slot_len[s] = r.len;
        slot_tag[s] = r.tag;
        if (backlog[f] == 0) head_slot[f] = s;
        else slot_next[tail_slot[f]] = s;
        tail_slot[f] = s;
        backlog[f]++;
        held++;
        return res;
    endfunction

    function automatic t_sched_res dequeue_pkt(t_pkt_req r);
        t_sched_res  res;
        bit          from_old;
        int          f;
        int          s;
        logic [31:0] c;
        res = '{ST_EMPTY, 10'd0, 16'd0, 32'd0};
        if (held == 0) return res;
        forever begin
            if (new_v) from_old = 0;
            else if (!cfg_basic && old_v) from_old = 1;
            else return res;
            f = from_old ? old_first : new_first;
            c = credit[f];
            if (c == 0 || c[31]) begin
                credit[f] = c + {11'd0, cfg_quantum};
                ring_pop(from_old);
                ring_push(!cfg_basic, f);
            end else if (backlog[f] == 0) begin
                ring_pop(from_old);
                if (!cfg_basic && !from_old && old_v) ring_push(1, f);
                else begin
                    listed[f] = 0;
                    idle_since[f] = r.now;
                end
            end else begin
                s = head_slot[f];
                head_slot[f] = slot_next[s];
                slot_next[s] = free_head;
                free_head = s;
                backlog[f]--;
                held--;
                if (cfg_basic && backlog[f] == 0) begin
                    ring_pop(from_old);
                    listed[f] = 0;
                    idle_since[f] = r.now;
                end
                credit[f] = c - {16'd0, slot_len[s]};
                return '{ST_DEQUEUED, 10'(f), slot_len[s], slot_tag[s]};
            end
        end
    endfunction

    // Input side: bursts of transactions separated by random gaps.
    int burst_left = 5;
    int gap_left = 0;
    always @(negedge i_clk) begin : driver
        t_pkt_req r;
        bit       nv;
        nv = i_in_valid;
        if (took) begin
            took = 0;
            nv = 0;
        end
        if (!nv) begin
            if (gap_left > 0) gap_left--;
            else if (pending.size() > 0) begin
                r = pending.pop_front();
                i_command <= r.cmd;
                i_flow_hash <= r.hash;
                i_pkt_len <= r.len;
                i_pkt_tag <= r.tag;
                i_now <= r.now;
                nv = 1;
                if (--burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
        i_in_valid <= nv;
    end

    // Output side: runs of always-ready, random, or mostly-stalled behavior.
    int run_left = 0;
    int run_kind = 0;
    always @(negedge i_clk) begin : receiver
        bit rdy;
        if (hold_cycles > 0) begin
            hold_cycles--;
            rdy = 0;
        end else begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 60);
                run_kind = $urandom_range(0, 2);
            end
            run_left--;
            case (run_kind)
                0: rdy = 1;
                1: rdy = $urandom_range(0, 1);
                default: rdy = ($urandom_range(0, 4) == 0);
            endcase
        end
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin : monitor
        t_pkt_req   r;
        t_sched_res e;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                r = '{i_command, i_flow_hash, i_pkt_len, i_pkt_tag, i_now};
                expected.push_back(r.cmd == CMD_DEQ ? dequeue_pkt(r) : enqueue_pkt(r));
                took = 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected.size() == 0) begin
                    $error("result with no transaction outstanding, status %0d", o_status);
                    errors++;
                end else begin
                    e = expected.pop_front();
                    if (o_status < 5) n_status[o_status]++;
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status);
                        errors++;
                    end
                    if (o_out_flow !== e.flow) begin
                        $error("out_flow: expected %0d, got %0d", e.flow, o_out_flow);
                        errors++;
                    end
                    if (o_out_len !== e.len) begin
                        $error("out_len: expected %0d, got %0d", e.len, o_out_len);
                        errors++;
                    end
                    if (o_out_tag !== e.tag) begin
                        $error("out_tag: expected %h, got %h", e.tag, o_out_tag);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOTAL_LIMIT:     cfg_total = data[13:0];
            CFG_FLOW_LIMIT:      cfg_flow_lim = data[13:0];
            CFG_QUANTUM:
                if (data[20:0] >= 1 && data[20:0] <= DRR_QUANTUM_MAX) cfg_quantum = data[20:0];
            CFG_START_CREDIT:    cfg_init_q = data[23:0];
            CFG_REFILL_DELAY:    cfg_refill = data;
            CFG_FLOW_MASK:       cfg_mask = data[9:0];
            CFG_BASIC_MODE:      cfg_basic = data[0];
            default: ;
        endcase
    endtask

    task automatic push_pkt(bit cmd, logic [31:0] hash, logic [15:0] len, logic [31:0] tag);
        tick += $urandom_range(0, 12);
        pending.push_back('{cmd, hash, len, tag, tick});
    endtask

    task automatic settle();
        while (pending.size() > 0 || i_in_valid || expected.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Random traffic over a given number of flows; hash high bits are noise above the mask.
    task automatic random_traffic(int n, int flows, int max_len, int deq_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 40) == 0) tick += $urandom_range(50, 400);
            push_pkt($urandom_range(0, 99) < deq_pct ? CMD_DEQ : CMD_ENQ,
                     ($urandom() & ~32'h3FF) | $urandom_range(0, flows - 1),
                     16'($urandom_range(1, max_len)), $urandom());
        end
    endtask

    initial begin
        tick = 32'hFFFF_FF80;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: empty dequeue and field extremes.
        push_pkt(CMD_DEQ, 32'h0, 16'd1, 32'h0);
        push_pkt(CMD_ENQ, 32'h0, 16'd1, 32'h0);
        push_pkt(CMD_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_pkt(CMD_ENQ, 32'h0000_0400, 16'd40000, 32'hA5A5_5A5A);
        push_pkt(CMD_ENQ, 32'h0000_03FF, 16'd100, 32'h1234_5678);
        repeat (5) push_pkt(CMD_DEQ, $urandom(), 16'($urandom()), $urandom());
        settle();

        // Tight limits, rejected quantum writes, an unknown index, zero start credit.
        write_reg(CFG_TOTAL_LIMIT, 32'd5);
        write_reg(CFG_FLOW_LIMIT, 32'd2);
        write_reg(CFG_QUANTUM, 32'd0);
        write_reg(CFG_QUANTUM, 32'd2000000);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_START_CREDIT, 32'd0);
        write_reg(CFG_REFILL_DELAY, 32'd0);
        for (int i = 0; i < 7; i++) push_pkt(CMD_ENQ, 32'(i / 3 + 1), 16'd100, $urandom());
        push_pkt(CMD_DEQ, 0, 0, 0);
        settle();

        // Leave a flow on the old list, then switch to basic mode: nothing to serve.
        write_reg(CFG_BASIC_MODE, 32'd1);
        push_pkt(CMD_DEQ, 0, 0, 0);
        push_pkt(CMD_ENQ, 32'd9, 16'd50, $urandom());
        push_pkt(CMD_DEQ, 0, 0, 0);
        push_pkt(CMD_DEQ, 0, 0, 0);
        settle();
        write_reg(CFG_BASIC_MODE, 32'd0);
        repeat (6) push_pkt(CMD_DEQ, 0, 0, 0);
        settle();

        // Restored limits, full field ranges, long idle refills.
        write_reg(CFG_TOTAL_LIMIT, 32'd8192);
        write_reg(CFG_FLOW_LIMIT, 32'd100);
        write_reg(CFG_QUANTUM, 32'd3028);
        write_reg(CFG_START_CREDIT, 32'd15140);
        write_reg(CFG_REFILL_DELAY, 32'd40);
        random_traffic(150, 12, 65535, 45);
        settle();

        // Upper extremes; a zero mask folds everything into one flow.
        write_reg(CFG_QUANTUM, 32'(DRR_QUANTUM_MAX));
        write_reg(CFG_START_CREDIT, 32'hFF_FFFF);
        write_reg(CFG_REFILL_DELAY, 32'hFFFF_FFFF);
        write_reg(CFG_FLOW_MASK, 32'd0);
        write_reg(CFG_FLOW_LIMIT, 32'd8192);
        random_traffic(80, 16, 65535, 45);
        settle();

        // Smallest quantum with short packets, so credit goes around many times.
        write_reg(CFG_QUANTUM, 32'd1);
        write_reg(CFG_START_CREDIT, 32'd0);
        write_reg(CFG_REFILL_DELAY, 32'd0);
        write_reg(CFG_FLOW_MASK, 32'h3FF);
        random_traffic(80, 6, 3, 45);
        settle();

        // Basic mode with tight limits; the receiver holds off so the input stalls.
        write_reg(CFG_BASIC_MODE, 32'd1);
        write_reg(CFG_QUANTUM, 32'd500);
        write_reg(CFG_FLOW_LIMIT, 32'd6);
        write_reg(CFG_TOTAL_LIMIT, 32'd40);
        hold_cycles = 400;
        random_traffic(100, 8, 2000, 35);
        settle();

        write_reg(CFG_BASIC_MODE, 32'd0);
        write_reg(CFG_TOTAL_LIMIT, 32'd0);
        random_traffic(6, 4, 100, 30);
        settle();
        write_reg(CFG_TOTAL_LIMIT, 32'd300);
        write_reg(CFG_FLOW_LIMIT, 32'd20);
        write_reg(CFG_REFILL_DELAY, 32'd40);
        write_reg(CFG_FLOW_MASK, 32'h0F5);
        random_traffic(140, 256, 9000, 45);
        settle();

        repeat (50) @(posedge i_clk);
        if (expected.size() != 0) begin
            $error("%0d results never arrived", expected.size());
            errors++;
        end
        $display("covered: %0d accepted, %0d total drops, %0d flow drops,",
                 n_status[0], n_status[1], n_status[2]);
        $display("         %0d dequeues, %0d empty answers, %0d errors",
                 n_status[3], n_status[4], errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/drr_pkg.sv
rtl/drr_ram.sv
rtl/drr_cfg.sv
rtl/drr_idx.sv
rtl/drr_flow_packet_scheduler.sv
tb/drr_flow_packet_scheduler_tb.sv
